// ===== src/zsw_pkg.sv =====
// Shared types, codes and byte-layout functions for the stored-mode ZIP writer.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package zsw_pkg;

    localparam int MAX_ENTRIES_DEF  = 64;
    localparam int MAX_NAME_LEN_DEF = 64;

    localparam logic [31:0] LFH_SIG  = 32'h04034B50;
    localparam logic [31:0] CDH_SIG  = 32'h02014B50;
    localparam logic [31:0] EOCD_SIG = 32'h06054B50;
    localparam logic [15:0] ZIP_VER  = 16'd20;
    localparam logic [31:0] CRC_POLY = 32'hEDB88320;
    localparam logic [31:0] ALL_ONES = 32'hFFFFFFFF;

    localparam int LFH_LEN  = 30;
    localparam int CDH_LEN  = 46;
    localparam int EOCD_LEN = 22;
    localparam int CRC_POS  = 14;
    localparam int CSZ_POS  = 18;
    localparam int USZ_POS  = 22;

    localparam logic [2:0] OP_BEGIN = 3'd0;
    localparam logic [2:0] OP_NAME  = 3'd1;
    localparam logic [2:0] OP_DATA  = 3'd2;
    localparam logic [2:0] OP_END   = 3'd3;
    localparam logic [2:0] OP_DIR   = 3'd4;

    localparam logic [2:0] ST_OK   = 3'd0;
    localparam logic [2:0] ST_SEQ  = 3'd1;
    localparam logic [2:0] ST_FULL = 3'd2;
    localparam logic [2:0] ST_NAME = 3'd3;
    localparam logic [2:0] ST_OVF  = 3'd4;

    localparam logic [1:0] KIND_BYTE  = 2'd0;
    localparam logic [1:0] KIND_PATCH = 2'd1;
    localparam logic [1:0] KIND_NONE  = 2'd2;

    localparam logic [0:0] CFG_MOD_TIME = 1'b0;
    localparam logic [0:0] CFG_MOD_DATE = 1'b1;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_NAME,
        PH_DATA,
        PH_DIR,
        PH_DONE
    } phase_t;

    typedef enum logic [2:0] {
        JOB_ERR,
        JOB_HDR,
        JOB_BYTE,
        JOB_NAME,
        JOB_PATCH
    } job_kind_t;

    typedef struct packed {
        logic [31:0] crc;
        logic [31:0] size;
        logic [31:0] hdr_off;
        logic [6:0]  nl;
    } entry_t;

    typedef struct packed {
        job_kind_t   kind;
        logic [2:0]  status;
        logic [7:0]  byte_val;
        logic        last;
        logic [6:0]  nl;
        logic [31:0] crc;
        logic [31:0] size;
        logic [31:0] hdr_off;
    } job_t;

    function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
        logic [31:0] c;
        c = crc_in ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
        end
        return c;
    endfunction

    function automatic logic [7:0] lfh_byte(input logic [4:0] i, input logic [15:0] t,
                                           input logic [15:0] d, input logic [6:0] nl);
        logic [7:0] b;
        case (i)
            5'd0:    b = LFH_SIG[7:0];
            5'd1:    b = LFH_SIG[15:8];
            5'd2:    b = LFH_SIG[23:16];
            5'd3:    b = LFH_SIG[31:24];
            5'd4:    b = ZIP_VER[7:0];
            5'd5:    b = ZIP_VER[15:8];
            5'd10:   b = t[7:0];
            5'd11:   b = t[15:8];
            5'd12:   b = d[7:0];
            5'd13:   b = d[15:8];
            5'd26:   b = {1'b0, nl};
            default: b = 8'd0;
        endcase
        return b;
    endfunction

    function automatic logic [7:0] cdh_byte(input logic [5:0] i, input logic [15:0] t,
                                           input logic [15:0] d, input entry_t e);
        logic [7:0] b;
        case (i)
            6'd0:    b = CDH_SIG[7:0];
            6'd1:    b = CDH_SIG[15:8];
            6'd2:    b = CDH_SIG[23:16];
            6'd3:    b = CDH_SIG[31:24];
            6'd4:    b = ZIP_VER[7:0];
            6'd5:    b = ZIP_VER[15:8];
            6'd6:    b = ZIP_VER[7:0];
            6'd7:    b = ZIP_VER[15:8];
            6'd12:   b = t[7:0];
            6'd13:   b = t[15:8];
            6'd14:   b = d[7:0];
            6'd15:   b = d[15:8];
            6'd16:   b = e.crc[7:0];
            6'd17:   b = e.crc[15:8];
            6'd18:   b = e.crc[23:16];
            6'd19:   b = e.crc[31:24];
            6'd20:   b = e.size[7:0];
            6'd21:   b = e.size[15:8];
            6'd22:   b = e.size[23:16];
            6'd23:   b = e.size[31:24];
            6'd24:   b = e.size[7:0];
            6'd25:   b = e.size[15:8];
            6'd26:   b = e.size[23:16];
            6'd27:   b = e.size[31:24];
            6'd28:   b = {1'b0, e.nl};
            6'd42:   b = e.hdr_off[7:0];
            6'd43:   b = e.hdr_off[15:8];
            6'd44:   b = e.hdr_off[23:16];
            6'd45:   b = e.hdr_off[31:24];
            default: b = 8'd0;
        endcase
        return b;
    endfunction

    function automatic logic [7:0] eocd_byte(input logic [4:0] i, input logic [15:0] cnt,
                                            input logic [31:0] total, input logic [31:0] start);
        logic [7:0] b;
        case (i)
            5'd0:    b = EOCD_SIG[7:0];
            5'd1:    b = EOCD_SIG[15:8];
            5'd2:    b = EOCD_SIG[23:16];
            5'd3:    b = EOCD_SIG[31:24];
            5'd8:    b = cnt[7:0];
            5'd9:    b = cnt[15:8];
            5'd10:   b = cnt[7:0];
            5'd11:   b = cnt[15:8];
            5'd12:   b = total[7:0];
            5'd13:   b = total[15:8];
            5'd14:   b = total[23:16];
            5'd15:   b = total[31:24];
            5'd16:   b = start[7:0];
            5'd17:   b = start[15:8];
            5'd18:   b = start[23:16];
            5'd19:   b = start[31:24];
            default: b = 8'd0;
        endcase
        return b;
    endfunction

endpackage

// ===== src/zsw_entry_mem.sv =====
// Directory entry memory: CRC, size, header offset and name length per entry.
// Depends on zsw_pkg; one write port, one registered read port with forwarding.
`timescale 1ns / 1ps

module zsw_entry_mem
    import zsw_pkg::*;
#(
    parameter int DEPTH = MAX_ENTRIES_DEF,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  entry_t        wdata,
    input  logic [AW-1:0] raddr,
    output entry_t        rdata
);

    entry_t mem [DEPTH];
    entry_t rdata_reg;

    // forward a same-edge write so the read port never shows a stale entry
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (we && (waddr == raddr))
        begin
            rdata_reg <= wdata;
        end
        else
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/zsw_name_mem.sv =====
// Name byte memory, one row of MAX_NAME_LEN bytes per entry.
// Depends on zsw_pkg; one write port, one registered read port with enable.
`timescale 1ns / 1ps

module zsw_name_mem
    import zsw_pkg::*;
#(
    parameter int DEPTH = MAX_ENTRIES_DEF * MAX_NAME_LEN_DEF,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [7:0]    wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [7:0]    rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/zsw_emitter.sv =====
// Result sequencer: holds one request's job and expands it into results.
// Depends on zsw_pkg; feeds a registered output stage.
`timescale 1ns / 1ps

module zsw_emitter
    import zsw_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        load,
    input  job_t        job_in,
    input  logic [15:0] dos_time,
    input  logic [15:0] dos_date,
    input  logic [7:0]  name_byte,
    output logic        take_ready,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  kind,
    output logic [7:0]  out_byte,
    output logic [31:0] patch_offset,
    output logic [31:0] patch_word,
    output logic [2:0]  status,
    output logic        last
);

    logic        busy_reg;
    job_t        job_reg;
    logic [4:0]  idx_reg;
    logic        out_valid_reg;
    logic [1:0]  kind_reg;
    logic [7:0]  byte_reg;
    logic [31:0] poff_reg;
    logic [31:0] pword_reg;
    logic [2:0]  status_reg;
    logic        last_reg;

    logic        out_free;
    logic        adv;
    logic        final_res;
    logic [1:0]  r_kind;
    logic [7:0]  r_byte;
    logic [31:0] r_poff;
    logic [31:0] r_pword;
    logic [2:0]  r_status;

    assign out_free   = !out_valid_reg || out_ready;
    assign adv        = busy_reg && out_free;
    assign take_ready = !busy_reg || (adv && final_res);

    always_comb
    begin
        r_kind    = KIND_BYTE;
        r_byte    = 8'd0;
        r_poff    = 32'd0;
        r_pword   = 32'd0;
        r_status  = ST_OK;
        final_res = 1'b1;
        case (job_reg.kind)
            JOB_HDR:
            begin
                r_byte    = lfh_byte(idx_reg, dos_time, dos_date, job_reg.nl);
                final_res = (idx_reg == 5'(LFH_LEN - 1));
            end
            JOB_BYTE:
            begin
                r_byte    = job_reg.byte_val;
                final_res = 1'b1;
            end
            JOB_NAME:
            begin
                r_byte    = name_byte;
                final_res = 1'b1;
            end
            JOB_PATCH:
            begin
                r_kind = KIND_PATCH;
                case (idx_reg)
                    5'd0:
                    begin
                        r_poff  = job_reg.hdr_off + 32'(CRC_POS);
                        r_pword = job_reg.crc;
                    end
                    5'd1:
                    begin
                        r_poff  = job_reg.hdr_off + 32'(CSZ_POS);
                        r_pword = job_reg.size;
                    end
                    default:
                    begin
                        r_poff  = job_reg.hdr_off + 32'(USZ_POS);
                        r_pword = job_reg.size;
                    end
                endcase
                final_res = (idx_reg == 5'd2);
            end
            default:
            begin
                r_kind   = KIND_NONE;
                r_status = job_reg.status;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            idx_reg       <= 5'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                busy_reg <= 1'b1;
                idx_reg  <= 5'd0;
            end
            else if (adv)
            begin
                busy_reg <= !final_res;
                idx_reg  <= idx_reg + 5'd1;
            end
            if (adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            job_reg <= job_in;
        end
        if (adv)
        begin
            kind_reg   <= r_kind;
            byte_reg   <= r_byte;
            poff_reg   <= r_poff;
            pword_reg  <= r_pword;
            status_reg <= r_status;
            // byte and name jobs carry their own last flag
            last_reg   <= ((job_reg.kind == JOB_BYTE) || (job_reg.kind == JOB_NAME)) ?
                          job_reg.last : final_res;
        end
    end

    assign out_valid    = out_valid_reg;
    assign kind         = kind_reg;
    assign out_byte     = byte_reg;
    assign patch_offset = poff_reg;
    assign patch_word   = pword_reg;
    assign status       = status_reg;
    assign last         = last_reg;

endmodule

// ===== src/zip_store_archive_writer_core.sv =====
// Top level of the stored-mode ZIP archive writer with CRC-32.
// Depends on zsw_pkg, zsw_entry_mem, zsw_name_mem and zsw_emitter.
`timescale 1ns / 1ps

// Stored-mode ZIP32 writer. Each request is one operation: begin entry, name
// byte, data byte, end entry or directory step. Name, data and directory
// requests stream back to back, a begin request holds the input while the
// local header bytes go out and an end request while the CRC and size patch
// words go out, as the result sequencer emits one result per cycle unless the
// output stalls. Per-entry directory data lives in an entry memory read ahead
// at the walk's current entry, with same-cycle write forwarding; name bytes
// live in a name memory read at accept and presented in the cycle after.
// Memories are not cleared after reset; the sequencing rules ensure every
// directory read hits a written row. The user must write configuration (DOS
// time and date) while idle; the block, always ready, does not enforce it.
module zip_store_archive_writer_core
    import zsw_pkg::*;
#(
    parameter int MAX_ENTRIES  = MAX_ENTRIES_DEF,
    parameter int MAX_NAME_LEN = MAX_NAME_LEN_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  operation,
    input  logic [7:0]  byte_value,
    input  logic [6:0]  name_length,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  kind,
    output logic [7:0]  out_byte,
    output logic [31:0] patch_offset,
    output logic [31:0] patch_word,
    output logic [2:0]  status,
    output logic        last
);

    localparam int CW   = $clog2(MAX_ENTRIES + 1);
    localparam int EIW  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int NDEP = MAX_ENTRIES * MAX_NAME_LEN;
    localparam int NAW  = (NDEP > 1) ? $clog2(NDEP) : 1;

    // configuration
    logic [15:0] dos_time_reg;
    logic [15:0] dos_date_reg;

    // entry and archive state
    phase_t      phase_reg, phase_next;
    logic [31:0] ao_reg, ao_next;
    logic [31:0] crc_reg, crc_next;
    logic [31:0] bcount_reg, bcount_next;
    logic [31:0] hdr_off_reg, hdr_off_next;
    logic [6:0]  name_left_reg, name_left_next;
    logic [6:0]  name_len_reg, name_len_next;
    logic [CW-1:0]  ecount_reg, ecount_next;
    logic [NAW-1:0] wr_base_reg, wr_base_next;
    logic [31:0] ctotal_reg, ctotal_next;

    // directory walk state
    logic [CW-1:0]  dentry_reg, dentry_next;
    logic [NAW-1:0] rd_base_reg, rd_base_next;
    logic [7:0]  dpos_reg, dpos_next;
    logic        dend_reg, dend_next;
    logic [31:0] dstart_reg, dstart_next;

    logic        acc;
    logic [2:0]  chk_status;
    logic        ok;
    logic [32:0] begin_end_off;
    logic        dir_first;
    logic        eff_end;
    logic [7:0]  eff_pos;
    logic [7:0]  rec_len;
    logic        dir_is_name;
    logic        dir_last;
    logic [7:0]  dir_lit;
    entry_t      ent_q;
    entry_t      ent_wdata;
    logic        ent_we;
    logic        name_we;
    logic [NAW-1:0] name_waddr;
    logic [NAW-1:0] name_raddr;
    logic [7:0]  name_q;
    job_t        job;
    logic        emit_ready;

    assign acc       = in_valid && in_ready;
    assign in_ready  = emit_ready;
    assign cfg_ready = 1'b1;

    assign begin_end_off = {1'b0, ao_reg} + 33'(LFH_LEN) + 33'(name_length);

    // order and limit checks, in priority order
    always_comb
    begin
        chk_status = ST_OK;
        case (operation)
            OP_BEGIN:
            begin
                if (phase_reg != PH_IDLE)
                    chk_status = ST_SEQ;
                else if (ecount_reg >= CW'(MAX_ENTRIES))
                    chk_status = ST_FULL;
                else if (32'(name_length) > 32'(MAX_NAME_LEN))
                    chk_status = ST_NAME;
                else if (begin_end_off[32])
                    chk_status = ST_OVF;
            end
            OP_NAME:
            begin
                if ((phase_reg != PH_NAME) || (ecount_reg >= CW'(MAX_ENTRIES)))
                    chk_status = ST_SEQ;
                else if (ao_reg == ALL_ONES)
                    chk_status = ST_OVF;
            end
            OP_DATA:
            begin
                if (phase_reg != PH_DATA)
                    chk_status = ST_SEQ;
                else if (ao_reg == ALL_ONES)
                    chk_status = ST_OVF;
            end
            OP_END:
            begin
                if ((phase_reg != PH_DATA) || (ecount_reg >= CW'(MAX_ENTRIES)))
                    chk_status = ST_SEQ;
            end
            OP_DIR:
            begin
                if ((phase_reg != PH_IDLE) && (phase_reg != PH_DIR))
                    chk_status = ST_SEQ;
                else if (ao_reg == ALL_ONES)
                    chk_status = ST_OVF;
            end
            default: chk_status = ST_SEQ;
        endcase
    end

    assign ok = (chk_status == ST_OK);

    // directory walk view; the walk pointers sit at zero until the first step
    assign dir_first   = (phase_reg == PH_IDLE);
    assign eff_end     = dir_first ? (ecount_reg == '0) : dend_reg;
    assign eff_pos     = dir_first ? 8'd0 : dpos_reg;
    assign rec_len     = 8'(CDH_LEN) + {1'b0, ent_q.nl};
    assign dir_is_name = !eff_end && (eff_pos >= 8'(CDH_LEN));
    assign dir_last    = eff_end && (eff_pos == 8'(EOCD_LEN - 1));
    assign dir_lit     = eff_end ?
        eocd_byte(eff_pos[4:0], 16'(ecount_reg), ctotal_reg, dir_first ? ao_reg : dstart_reg) :
        cdh_byte(eff_pos[5:0], dos_time_reg, dos_date_reg, ent_q);
    assign name_raddr  = rd_base_reg + NAW'(eff_pos - 8'(CDH_LEN));

    assign name_we    = acc && ok && (operation == OP_NAME);
    assign name_waddr = wr_base_reg + NAW'(name_len_reg - name_left_reg);
    assign ent_we     = acc && ok && (operation == OP_END);

    always_comb
    begin
        ent_wdata.crc     = ~crc_reg;
        ent_wdata.size    = bcount_reg;
        ent_wdata.hdr_off = hdr_off_reg;
        ent_wdata.nl      = name_len_reg;
    end

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (acc && ok)
        begin
            case (operation)
                OP_BEGIN: phase_next = (name_length != 7'd0) ? PH_NAME : PH_DATA;
                OP_NAME:  phase_next = (name_left_reg == 7'd1) ? PH_DATA : PH_NAME;
                OP_END:   phase_next = PH_IDLE;
                OP_DIR:   phase_next = dir_last ? PH_DONE : PH_DIR;
                default:  phase_next = phase_reg;
            endcase
        end
    end

    // datapath next values
    always_comb
    begin
        ao_next        = ao_reg;
        crc_next       = crc_reg;
        bcount_next    = bcount_reg;
        hdr_off_next   = hdr_off_reg;
        name_left_next = name_left_reg;
        name_len_next  = name_len_reg;
        ecount_next    = ecount_reg;
        wr_base_next   = wr_base_reg;
        ctotal_next    = ctotal_reg;
        dentry_next    = dentry_reg;
        rd_base_next   = rd_base_reg;
        dpos_next      = dpos_reg;
        dend_next      = dend_reg;
        dstart_next    = dstart_reg;
        if (acc && ok)
        begin
            case (operation)
                OP_BEGIN:
                begin
                    hdr_off_next   = ao_reg;
                    ao_next        = ao_reg + 32'(LFH_LEN);
                    name_len_next  = name_length;
                    name_left_next = name_length;
                    crc_next       = ALL_ONES;
                    bcount_next    = 32'd0;
                end
                OP_NAME:
                begin
                    ao_next        = ao_reg + 32'd1;
                    name_left_next = name_left_reg - 7'd1;
                end
                OP_DATA:
                begin
                    ao_next     = ao_reg + 32'd1;
                    crc_next    = crc_byte(crc_reg, byte_value);
                    bcount_next = bcount_reg + 32'd1;
                end
                OP_END:
                begin
                    ecount_next  = ecount_reg + CW'(1);
                    wr_base_next = wr_base_reg + NAW'(MAX_NAME_LEN);
                    ctotal_next  = ctotal_reg + 32'(CDH_LEN) + 32'(name_len_reg);
                end
                OP_DIR:
                begin
                    ao_next = ao_reg + 32'd1;
                    if (dir_first)
                        dstart_next = ao_reg;
                    if (eff_end)
                    begin
                        dpos_next = eff_pos + 8'd1;
                        dend_next = 1'b1;
                    end
                    else if ((eff_pos + 8'd1) == rec_len)
                    begin
                        // advance to the next entry record
                        dentry_next  = dentry_reg + CW'(1);
                        rd_base_next = rd_base_reg + NAW'(MAX_NAME_LEN);
                        dpos_next    = 8'd0;
                        dend_next    = ((dentry_reg + CW'(1)) == ecount_reg);
                    end
                    else
                    begin
                        dpos_next = eff_pos + 8'd1;
                        dend_next = 1'b0;
                    end
                end
                default: ao_next = ao_reg;
            endcase
        end
    end

    // job handed to the result sequencer
    always_comb
    begin
        job.kind     = JOB_ERR;
        job.status   = chk_status;
        job.byte_val = byte_value;
        job.last     = 1'b1;
        job.nl       = name_length;
        job.crc      = ~crc_reg;
        job.size     = bcount_reg;
        job.hdr_off  = hdr_off_reg;
        if (ok)
        begin
            case (operation)
                OP_BEGIN: job.kind = JOB_HDR;
                OP_NAME:  job.kind = JOB_BYTE;
                OP_DATA:  job.kind = JOB_BYTE;
                OP_END:   job.kind = JOB_PATCH;
                OP_DIR:
                begin
                    job.kind     = dir_is_name ? JOB_NAME : JOB_BYTE;
                    job.byte_val = dir_lit;
                    job.last     = dir_last;
                end
                default:  job.kind = JOB_ERR;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dos_time_reg  <= 16'd0;
            dos_date_reg  <= 16'd0;
            phase_reg     <= PH_IDLE;
            ao_reg        <= 32'd0;
            crc_reg       <= ALL_ONES;
            bcount_reg    <= 32'd0;
            hdr_off_reg   <= 32'd0;
            name_left_reg <= 7'd0;
            name_len_reg  <= 7'd0;
            ecount_reg    <= '0;
            wr_base_reg   <= '0;
            ctotal_reg    <= 32'd0;
            dentry_reg    <= '0;
            rd_base_reg   <= '0;
            dpos_reg      <= 8'd0;
            dend_reg      <= 1'b0;
            dstart_reg    <= 32'd0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_MOD_TIME)
                    dos_time_reg <= cfg_data;
                else
                    dos_date_reg <= cfg_data;
            end
            phase_reg     <= phase_next;
            ao_reg        <= ao_next;
            crc_reg       <= crc_next;
            bcount_reg    <= bcount_next;
            hdr_off_reg   <= hdr_off_next;
            name_left_reg <= name_left_next;
            name_len_reg  <= name_len_next;
            ecount_reg    <= ecount_next;
            wr_base_reg   <= wr_base_next;
            ctotal_reg    <= ctotal_next;
            dentry_reg    <= dentry_next;
            rd_base_reg   <= rd_base_next;
            dpos_reg      <= dpos_next;
            dend_reg      <= dend_next;
            dstart_reg    <= dstart_next;
        end
    end

    // read ahead at the entry the walk will sit on after this edge
    zsw_entry_mem #(
        .DEPTH (MAX_ENTRIES)
    ) u_entry_mem (
        .clk   (clk),
        .we    (ent_we),
        .waddr (ecount_reg[EIW-1:0]),
        .wdata (ent_wdata),
        .raddr (dentry_next[EIW-1:0]),
        .rdata (ent_q)
    );

    zsw_name_mem #(
        .DEPTH (NDEP)
    ) u_name_mem (
        .clk   (clk),
        .we    (name_we),
        .waddr (name_waddr),
        .wdata (byte_value),
        .re    (acc),
        .raddr (name_raddr),
        .rdata (name_q)
    );

    zsw_emitter u_emitter (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (acc),
        .job_in       (job),
        .dos_time     (dos_time_reg),
        .dos_date     (dos_date_reg),
        .name_byte    (name_q),
        .take_ready   (emit_ready),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .kind         (kind),
        .out_byte     (out_byte),
        .patch_offset (patch_offset),
        .patch_word   (patch_word),
        .status       (status),
        .last         (last)
    );

    // the archive is finished only after the end record has been walked
    a_done_in_end: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_DONE) |-> dend_reg)
        else $error("done phase outside end record");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ecount_reg <= CW'(MAX_ENTRIES))
        else $error("entry count beyond table");

    a_name_left: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_NAME) |-> (name_left_reg != 7'd0))
        else $error("name phase with no name bytes left");

    a_hdr_off: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && ok && (operation == OP_BEGIN)) |=> (hdr_off_reg == $past(ao_reg)))
        else $error("header offset not captured at begin");

endmodule

// ===== tb/tb_top.sv =====
// Testbench for the stored-mode ZIP archive writer core: directed and random
// entry sequences checked against an in-bench predictor of the byte stream.
// Depends on zsw_pkg and zip_store_archive_writer_core.
`timescale 1ns / 1ps

module tb_top
    import zsw_pkg::*;
();

    localparam int NUM_ENTRIES = 64;
    localparam int NAME_MAX    = 64;
    localparam int WATCHDOG    = 20000;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  out_byte;
        logic [31:0] patch_offset;
        logic [31:0] patch_word;
        logic [2:0]  status;
        logic        last;
    } result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [2:0]  operation = '0;
    logic [7:0]  byte_value = '0;
    logic [6:0]  name_length = '0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [0:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [1:0]  kind;
    logic [7:0]  out_byte;
    logic [31:0] patch_offset;
    logic [31:0] patch_word;
    logic [2:0]  status;
    logic        last;

    zip_store_archive_writer_core DUT (.*);

    always #5 clk = ~clk;

    // Predictor state: a private copy of the archive writer.
    logic [15:0] m_time, m_date;
    logic [31:0] arc_off, crc_run, byte_cnt, hdr_off, dir_start;
    phase_t      ph;
    int          names_left, n_entries, cursor;
    logic [31:0] e_crc [NUM_ENTRIES];
    logic [31:0] e_size [NUM_ENTRIES];
    logic [31:0] e_off [NUM_ENTRIES];
    int          e_nl [NUM_ENTRIES];
    logic [7:0]  e_name [NUM_ENTRIES][NAME_MAX];

    result_t     expected_results[$];
    int          n_errors = 0;
    int          n_results = 0;
    int          n_requests = 0;
    int          idle_cycles = 0;
    bit          calm = 1'b0;   // while set, neither side idles

    function automatic logic [31:0] crc_step(logic [31:0] c, logic [7:0] b);
        c = c ^ {24'd0, b};
        for (int i = 0; i < 8; i++)
            c = c[0] ? (32'hEDB88320 ^ (c >> 1)) : (c >> 1);
        return c;
    endfunction

    function automatic void queue_result(result_t r);
        expected_results.insert(expected_results.size(), r);
    endfunction

    function automatic void push_byte(logic [7:0] b, logic l);
        queue_result('{KIND_BYTE, b, 32'd0, 32'd0, ST_OK, l});
    endfunction

    function automatic void push_error(logic [2:0] s);
        queue_result('{KIND_NONE, 8'd0, 32'd0, 32'd0, s, 1'b1});
    endfunction

    function automatic int dir_total();
        int t = 0;
        for (int i = 0; i < n_entries; i++) t += 46 + e_nl[i];
        return t;
    endfunction

    // Byte c of the central directory followed by the end record.
    function automatic logic [7:0] dir_stream_byte(int c);
        logic [8*46-1:0] rec;
        for (int i = 0; i < n_entries; i++) begin
            if (c < 46 + e_nl[i]) begin
                if (c >= 46) return e_name[i][c-46];
                rec = '0;
                rec[0*8 +: 32]  = 32'h02014B50;
                rec[4*8 +: 16]  = 16'd20;
                rec[6*8 +: 16]  = 16'd20;
                rec[12*8 +: 16] = m_time;
                rec[14*8 +: 16] = m_date;
                rec[16*8 +: 32] = e_crc[i];
                rec[20*8 +: 32] = e_size[i];
                rec[24*8 +: 32] = e_size[i];
                rec[28*8 +: 16] = 16'(e_nl[i]);
                rec[42*8 +: 32] = e_off[i];
                return rec[c*8 +: 8];
            end
            c -= 46 + e_nl[i];
        end
        rec = '0;
        rec[0*8 +: 32]  = 32'h06054B50;
        rec[8*8 +: 16]  = 16'(n_entries);
        rec[10*8 +: 16] = 16'(n_entries);
        rec[12*8 +: 32] = 32'(dir_total());
        rec[16*8 +: 32] = dir_start;
        return (c < 22) ? rec[c*8 +: 8] : 8'd0;
    endfunction

    function automatic void predict_request(logic [2:0] op, logic [7:0] b, logic [6:0] nl);
        logic [8*30-1:0] hdr;
        logic [31:0]     fin;
        case (op)
            OP_BEGIN: begin
                if (ph != PH_IDLE) push_error(ST_SEQ);
                else if (n_entries >= NUM_ENTRIES) push_error(ST_FULL);
                else if (nl > NAME_MAX) push_error(ST_NAME);
                else if (33'(arc_off) + 33'd30 + 33'(nl) > 33'hFFFFFFFF) push_error(ST_OVF);
                else begin
                    hdr = '0;
                    hdr[0*8 +: 32]  = 32'h04034B50;
                    hdr[4*8 +: 16]  = 16'd20;
                    hdr[10*8 +: 16] = m_time;
                    hdr[12*8 +: 16] = m_date;
                    hdr[26*8 +: 16] = 16'(nl);
                    for (int k = 0; k < 30; k++) push_byte(hdr[k*8 +: 8], k == 29);
                    hdr_off = arc_off;
                    arc_off += 30;
                    e_nl[n_entries] = nl;
                    names_left = nl;
                    crc_run = '1;
                    byte_cnt = 0;
                    ph = (nl != 0) ? PH_NAME : PH_DATA;
                end
            end
            OP_NAME: begin
                if (ph != PH_NAME) push_error(ST_SEQ);
                else if (arc_off == '1) push_error(ST_OVF);
                else begin
                    e_name[n_entries][e_nl[n_entries] - names_left] = b;
                    push_byte(b, 1'b1);
                    arc_off++;
                    names_left--;
                    if (names_left == 0) ph = PH_DATA;
                end
            end
            OP_DATA: begin
                if (ph != PH_DATA) push_error(ST_SEQ);
                else if (arc_off == '1) push_error(ST_OVF);
                else begin
                    crc_run = crc_step(crc_run, b);
                    byte_cnt++;
                    arc_off++;
                    push_byte(b, 1'b1);
                end
            end
            OP_END: begin
                if (ph != PH_DATA) push_error(ST_SEQ);
                else begin
                    fin = ~crc_run;
                    queue_result('{KIND_PATCH, 8'd0, hdr_off + 14, fin, ST_OK, 1'b0});
                    queue_result('{KIND_PATCH, 8'd0, hdr_off + 18, byte_cnt, ST_OK, 1'b0});
                    queue_result('{KIND_PATCH, 8'd0, hdr_off + 22, byte_cnt, ST_OK, 1'b1});
                    e_crc[n_entries] = fin;
                    e_size[n_entries] = byte_cnt;
                    e_off[n_entries] = hdr_off;
                    n_entries++;
                    ph = PH_IDLE;
                end
            end
            OP_DIR: begin
                if (ph != PH_IDLE && ph != PH_DIR) push_error(ST_SEQ);
                else if (arc_off == '1) push_error(ST_OVF);
                else begin
                    if (ph == PH_IDLE) begin
                        dir_start = arc_off;
                        cursor = 0;
                        ph = PH_DIR;
                    end
                    b = dir_stream_byte(cursor);
                    cursor++;
                    arc_off++;
                    if (cursor >= dir_total() + 22) ph = PH_DONE;
                    push_byte(b, ph == PH_DONE);
                end
            end
            default: push_error(ST_SEQ);
        endcase
    endfunction

    // Send one request; the prediction is made at the accepting edge.
    // Valid stays high into the next request unless that one idles first.
    task automatic send_request(logic [2:0] op, logic [7:0] b, logic [6:0] nl);
        while (!calm && $urandom_range(99) < 6) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        operation <= op;
        byte_value <= b;
        name_length <= nl;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        predict_request(op, b, nl);
        n_requests++;
    endtask

    task automatic write_register(logic [0:0] idx, logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        if (idx == CFG_MOD_TIME) m_time = val;
        else m_date = val;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Drop valid, wait for the block to drain, then let the pipeline settle.
    task automatic drain();
        in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // Send one well-formed entry: begin, name bytes, data bytes, end.
    task automatic write_entry(int nl, int ndata);
        send_request(OP_BEGIN, 8'($urandom_range(255)), 7'(nl));
        for (int i = 0; i < nl; i++)
            send_request(OP_NAME, 8'($urandom_range(255)), 7'($urandom));
        for (int i = 0; i < ndata; i++)
            send_request(OP_DATA, 8'($urandom_range(255)), 7'($urandom));
        send_request(OP_END, 8'($urandom_range(255)), 7'($urandom));
    endtask

    task automatic test_directed();
        logic [6:0] bad_nl;
        send_request(OP_DATA, 8'hFF, 7'h7F);     // data outside an entry
        send_request(OP_END, 8'h00, 7'h00);
        send_request(OP_NAME, 8'h55, 7'h00);
        send_request(3'd5, 8'h00, 7'h00);       // undefined operation codes
        send_request(3'd7, 8'hAA, 7'h7F);
        bad_nl = 7'd65;
        send_request(OP_BEGIN, 8'h00, bad_nl);  // name too long
        send_request(OP_BEGIN, 8'h00, 7'h7F);
        send_request(OP_BEGIN, 8'h00, 7'd0);    // empty name goes straight to data
        send_request(OP_BEGIN, 8'h00, 7'd0);    // begin inside an entry
        send_request(OP_DATA, 8'h00, 7'd0);
        send_request(OP_DATA, 8'hFF, 7'd0);
        send_request(OP_DIR, 8'h00, 7'd0);      // directory step inside an entry
        send_request(OP_END, 8'h00, 7'd0);
        send_request(OP_BEGIN, 8'h00, 7'd2);
        send_request(OP_DATA, 8'h12, 7'd0);     // data while name pending
        send_request(OP_NAME, 8'h00, 7'd0);
        send_request(OP_NAME, 8'hFF, 7'd0);
        send_request(OP_NAME, 8'h41, 7'd0);     // name past its length
        send_request(OP_END, 8'h00, 7'd0);      // zero-byte entry
        drain();
    endtask

    task automatic test_config_sweep();
        write_register(CFG_MOD_TIME, 16'hFFFF);
        write_register(CFG_MOD_DATE, 16'h0000);
        write_entry(1, 2);
        drain();
        write_register(CFG_MOD_TIME, 16'($urandom));
        write_register(CFG_MOD_DATE, 16'($urandom));
    endtask

    // Random entries mixed with noise requests; the directory stays closed.
    task automatic test_random_entries();
        logic [2:0] op;
        for (int k = 0; k < 12; k++) begin
            if (k == 4 || k == 9) begin
                write_entry($urandom_range(4), $urandom_range(12));
            end else begin
                op = 3'($urandom);
                if (op == OP_DIR) op = OP_NAME;
                send_request(op, 8'($urandom), 7'($urandom));
            end
        end
        drain();
    endtask

    // Close any open entry, walk the directory to its end and poke after it.
    task automatic test_directory();
        while (ph == PH_NAME) send_request(OP_NAME, 8'($urandom), 7'($urandom));
        if (ph == PH_DATA) send_request(OP_END, 8'($urandom), 7'($urandom));
        calm = 1'b1;
        while (ph != PH_DONE) send_request(OP_DIR, 8'($urandom), 7'($urandom));
        calm = 1'b0;
        send_request(OP_DIR, 8'h00, 7'd0);      // archive already complete
        send_request(OP_BEGIN, 8'h00, 7'd0);
        drain();
    endtask

    // Receiver: random stalls, compare each result with the oldest prediction.
    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid && out_ready) begin
                result_t exp_r;
                if (expected_results.size() == 0) begin
                    $error("unexpected result kind=%0d byte=%0h", kind, out_byte);
                    n_errors++;
                end else begin
                    exp_r = expected_results.pop_front();
                    n_results++;
                    if (kind !== exp_r.kind) begin
                        $error("kind: expected %0d, got %0d", exp_r.kind, kind); n_errors++;
                    end
                    if (out_byte !== exp_r.out_byte) begin
                        $error("out_byte: expected %0h, got %0h", exp_r.out_byte, out_byte);
                        n_errors++;
                    end
                    if (patch_offset !== exp_r.patch_offset) begin
                        $error("patch_offset: expected %0h, got %0h", exp_r.patch_offset,
                               patch_offset);
                        n_errors++;
                    end
                    if (patch_word !== exp_r.patch_word) begin
                        $error("patch_word: expected %0h, got %0h", exp_r.patch_word, patch_word);
                        n_errors++;
                    end
                    if (status !== exp_r.status) begin
                        $error("status: expected %0d, got %0d", exp_r.status, status); n_errors++;
                    end
                    if (last !== exp_r.last) begin
                        $error("last: expected %0d, got %0d", exp_r.last, last); n_errors++;
                    end
                end
            end
            out_ready <= calm || ($urandom_range(99) >= 6);
        end
    end

    // Watchdog: count cycles with no accepted request, result or write.
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG) begin
            $display("tb_top failed");
            $finish;
        end
    end

    initial begin
        m_time = 0; m_date = 0;
        arc_off = 0; crc_run = '1; byte_cnt = 0; hdr_off = 0; dir_start = 0;
        ph = PH_IDLE; names_left = 0; n_entries = 0; cursor = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_config_sweep();
        test_random_entries();
        test_directory();
        $display("Covered %0d requests, %0d results, %0d entries and a full directory walk.",
                 n_requests, n_results, n_entries);
        if (n_errors == 0 && expected_results.size() == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule
